@@ hw/rtl/tws_pkg.sv @@
package tws_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_COMMAND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUMI_COMMAND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_LIMIT   = 2'd2;

    localparam logic [7:0]  TEMP_COMMAND_RST = 8'd3;
    localparam logic [7:0]  HUMI_COMMAND_RST = 8'd5;
    localparam logic [15:0] WAIT_LIMIT_RST   = 16'hFFFF;

    // transmission start pattern, one entry per step, indexed by step number
    localparam logic [7:0] START_SCK = 8'b0011_0110;
    localparam logic [7:0] START_DAT = 8'b0110_0011;
    localparam logic [2:0] START_LAST = 3'd6;

    typedef struct packed {
        logic [7:0]  temp_command;
        logic [7:0]  humi_command;
        logic [15:0] wait_limit;
    } cfg_t;

    typedef struct packed {
        logic        sck;
        logic        data_drive;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  error_count;
        logic [15:0] reading;
        logic [7:0]  checksum;
    } res_t;

endpackage

@@ hw/rtl/two_wire_sensor_measure_engine.sv @@
// Bit-level master for a two-wire humidity/temperature sensor. Each input transfer is one
// pin-phase tick carrying the sampled data line and a start request with its mode; each
// tick yields exactly one result transfer with the sck level and data drive (0 pulls low,
// 1 releases) to put on the pins, plus busy, done, the error count of the current or last
// transaction, the last 16-bit reading and the unchecked checksum byte. The phase sequencer
// computes the tick in one step from its state registers into the result register, so a new
// tick is taken every cycle while the result register is empty or being drained. Config
// registers (0 temperature command, 1 humidity command, 2 wait limit) are written through
// the cfg channel, which is always ready.
module two_wire_sensor_measure_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             start_req,
    input  logic                             mode,
    input  logic                             data_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             sck,
    output logic                             data_drive,
    output logic                             busy_res,
    output logic                             done_res,
    output logic [1:0]                       error_count,
    output logic [15:0]                      reading,
    output logic [7:0]                       checksum,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tws_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                      cfg_data
);

    tws_pkg::cfg_t cfg;
    tws_pkg::res_t res;
    tws_pkg::res_t res_reg;
    logic          out_valid_reg;
    logic          step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    tws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tws_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .start_req (start_req),
        .mode      (mode),
        .data_in   (data_in),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign sck         = res_reg.sck;
    assign data_drive  = res_reg.data_drive;
    assign busy_res    = res_reg.busy_res;
    assign done_res    = res_reg.done_res;
    assign error_count = res_reg.error_count;
    assign reading     = res_reg.reading;
    assign checksum    = res_reg.checksum;

endmodule

@@ hw/rtl/tws_cfg.sv @@
module tws_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tws_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                      cfg_data,
    output tws_pkg::cfg_t                    cfg
);

    tws_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_command <= tws_pkg::TEMP_COMMAND_RST;
            cfg_reg.humi_command <= tws_pkg::HUMI_COMMAND_RST;
            cfg_reg.wait_limit   <= tws_pkg::WAIT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tws_pkg::CFG_TEMP_COMMAND: cfg_reg.temp_command <= cfg_data[7:0];
                tws_pkg::CFG_HUMI_COMMAND: cfg_reg.humi_command <= cfg_data[7:0];
                tws_pkg::CFG_WAIT_LIMIT:   cfg_reg.wait_limit   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ hw/rtl/tws_seq.sv @@
module tws_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           start_req,
    input  logic           mode,
    input  logic           data_in,
    input  tws_pkg::cfg_t  cfg,
    output tws_pkg::res_t  res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_WR_LO,
        PH_WR_HI,
        PH_WR_ACK_HI,
        PH_WR_ACK_LO,
        PH_WAIT,
        PH_RD_HI,
        PH_RD_LO,
        PH_RD_ACK_LO,
        PH_RD_ACK_HI,
        PH_RD_ACK_END
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] measured_word_reg, measured_word_next;
    logic [7:0]  crc_byte_reg, crc_byte_next;
    logic [1:0]  error_tally_reg, error_tally_next;
    logic [15:0] wait_count_reg, wait_count_next;

    logic        sck_c, dat_c, busy_c, done_c;
    logic        cur_bit;
    logic [15:0] limit;
    logic [15:0] wait_inc;
    logic [1:0]  err_add;

    // commands go out msb first
    assign cur_bit  = shift_byte_reg[~bit_index_reg];
    assign limit    = (cfg.wait_limit == 16'd0) ? 16'd1 : cfg.wait_limit;
    assign wait_inc = wait_count_reg + 16'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        byte_index_next    = byte_index_reg;
        shift_byte_next    = shift_byte_reg;
        measured_word_next = measured_word_reg;
        crc_byte_next      = crc_byte_reg;
        wait_count_next    = wait_count_reg;
        err_add            = 2'd0;
        sck_c              = 1'b0;
        dat_c              = 1'b1;
        busy_c             = 1'b1;
        done_c             = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                busy_c = 1'b0;
                if (start_req)
                begin
                    shift_byte_next = mode ? cfg.humi_command : cfg.temp_command;
                    bit_index_next  = 3'd0;
                    byte_index_next = 2'd0;
                    phase_next      = PH_START;
                end
            end
            PH_START:
            begin
                sck_c = tws_pkg::START_SCK[bit_index_reg];
                dat_c = tws_pkg::START_DAT[bit_index_reg];
                if (bit_index_reg == tws_pkg::START_LAST)
                begin
                    bit_index_next = 3'd0;
                    phase_next     = PH_WR_LO;
                end
                else
                begin
                    bit_index_next = bit_index_reg + 3'd1;
                end
            end
            PH_WR_LO:
            begin
                dat_c      = cur_bit;
                phase_next = PH_WR_HI;
            end
            PH_WR_HI:
            begin
                sck_c = 1'b1;
                dat_c = cur_bit;
                if (bit_index_reg == 3'd7)
                    phase_next = PH_WR_ACK_HI;
                else
                begin
                    bit_index_next = bit_index_reg + 3'd1;
                    phase_next     = PH_WR_LO;
                end
            end
            PH_WR_ACK_HI:
            begin
                sck_c      = 1'b1;
                err_add    = {1'b0, data_in};
                phase_next = PH_WR_ACK_LO;
            end
            PH_WR_ACK_LO:
            begin
                wait_count_next = 16'd0;
                phase_next      = PH_WAIT;
            end
            PH_WAIT:
            begin
                if (data_in)
                    wait_count_next = wait_inc;
                if (!data_in || wait_inc >= limit)
                begin
                    bit_index_next  = 3'd0;
                    byte_index_next = 2'd0;
                    shift_byte_next = 8'd0;
                    phase_next      = PH_RD_HI;
                end
                // timeout still proceeds to the read
                if (data_in && wait_inc >= limit)
                    err_add = 2'd1;
            end
            PH_RD_HI:
            begin
                sck_c = 1'b1;
                if (data_in)
                    shift_byte_next[~bit_index_reg] = 1'b1;
                phase_next = PH_RD_LO;
            end
            PH_RD_LO:
            begin
                if (bit_index_reg == 3'd7)
                    phase_next = PH_RD_ACK_LO;
                else
                begin
                    bit_index_next = bit_index_reg + 3'd1;
                    phase_next     = PH_RD_HI;
                end
            end
            PH_RD_ACK_LO:
            begin
                dat_c = (byte_index_reg < 2'd2) ? 1'b0 : 1'b1;
                case (byte_index_reg)
                    2'd0:    measured_word_next[15:8] = shift_byte_reg;
                    2'd1:    measured_word_next[7:0]  = shift_byte_reg;
                    default: crc_byte_next            = shift_byte_reg;
                endcase
                phase_next = PH_RD_ACK_HI;
            end
            PH_RD_ACK_HI:
            begin
                sck_c      = 1'b1;
                dat_c      = (byte_index_reg < 2'd2) ? 1'b0 : 1'b1;
                phase_next = PH_RD_ACK_END;
            end
            PH_RD_ACK_END:
            begin
                if (byte_index_reg >= 2'd2)
                begin
                    done_c     = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    byte_index_next = byte_index_reg + 2'd1;
                    bit_index_next  = 3'd0;
                    shift_byte_next = 8'd0;
                    phase_next      = PH_RD_HI;
                end
            end
            default:
            begin
                busy_c     = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase

        if (phase_reg == PH_IDLE)
            error_tally_next = start_req ? 2'd0 : error_tally_reg;
        else if (err_add != 2'd0 && error_tally_reg != 2'd3)
            error_tally_next = error_tally_reg + 2'd1;
        else
            error_tally_next = error_tally_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_index_reg     <= 3'd0;
            byte_index_reg    <= 2'd0;
            shift_byte_reg    <= 8'd0;
            measured_word_reg <= 16'd0;
            crc_byte_reg      <= 8'd0;
            error_tally_reg   <= 2'd0;
            wait_count_reg    <= 16'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            bit_index_reg     <= bit_index_next;
            byte_index_reg    <= byte_index_next;
            shift_byte_reg    <= shift_byte_next;
            measured_word_reg <= measured_word_next;
            crc_byte_reg      <= crc_byte_next;
            error_tally_reg   <= error_tally_next;
            wait_count_reg    <= wait_count_next;
        end
    end

    // result carries the state as left by this tick
    always_comb
    begin
        res.sck         = sck_c;
        res.data_drive  = dat_c;
        res.busy_res    = busy_c;
        res.done_res    = done_c;
        res.error_count = error_tally_next;
        res.reading     = measured_word_next;
        res.checksum    = crc_byte_next;
    end

endmodule
